>>> hw/rtl/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg: shared types and helpers for the binary heap priority queue
// Key and word types, status and command codes, sequencer and cell phase
// enums, and the width helpers that follow from the queue capacity.
// ----------------------------------------------------------------------------
package bhpq_pkg;

	localparam int KEY_W         = 32;
	localparam int COUNT_FIELD_W = 7;
	localparam int CAPACITY_DEF  = 64;

	typedef logic signed [KEY_W-1:0] key_t;

	// operation codes carried in the input word
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic cmd;
		key_t key;
	} in_word_t;

	typedef struct packed {
		key_t                     popped_key;
		logic [1:0]               status;
		logic [COUNT_FIELD_W-1:0] stored_count;
		key_t                     top_key;
	} out_word_t;

	// key travelling between neighboring levels
	typedef struct packed {
		logic valid;
		key_t value;
	} tok_t;

	// per-level report back to the sequencer
	typedef struct packed {
		logic done;
		logic wr;
		key_t wr_value;
	} cell_stat_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DN,
		PH_UP
	} cell_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_FETCH,
		ST_LOAD,
		ST_RUN,
		ST_DONE
	} hpq_state_t;

	// entry count width: holds 0 .. cap
	function automatic int cnt_w(input int cap);
		return $clog2(cap + 1);
	endfunction

	// offset of a slot within its level
	function automatic int ofs_w(input int cap);
		return ($clog2(cap + 1) > 2) ? $clog2(cap + 1) - 1 : 1;
	endfunction

	// row within one even/odd bank of a level
	function automatic int row_w(input int cap);
		return (ofs_w(cap) > 1) ? ofs_w(cap) - 1 : 1;
	endfunction

	// level number
	function automatic int lvl_w(input int cap);
		return $clog2($clog2(cap + 1));
	endfunction

	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// true when key a must sit above key b under the current order
	function automatic logic ranks_above(input key_t a, input key_t b, input logic largest);
		return largest ? (a > b) : (a < b);
	endfunction

endpackage

>>> hw/rtl/bhpq_ram.sv
// ----------------------------------------------------------------------------
// bhpq_ram: generic single-port-write, single-port-read RAM
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bhpq_ram #(
	parameter int WIDTH = bhpq_pkg::KEY_W,
	parameter int DEPTH = 2
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [bhpq_pkg::addr_w(DEPTH)-1:0]  waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic [bhpq_pkg::addr_w(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/bhpq_cell.sv
// ----------------------------------------------------------------------------
// bhpq_cell: one heap level
// Holds the slots of one level in an even and an odd bank. A key moving
// down reads both children from the level below, keeps the better one here
// and hands the key on; a key moving up reads its parent from the level
// above and trades places while it ranks strictly above.
// ----------------------------------------------------------------------------
module bhpq_cell #(
	parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF,
	parameter int LEVEL    = 0
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    largest,
	input  logic [bhpq_pkg::cnt_w(CAPACITY)-1:0]    count,
	// key arriving from the level above, moving down
	input  bhpq_pkg::tok_t                          dn_in,
	input  logic [bhpq_pkg::ofs_w(CAPACITY)-1:0]    dn_in_ofs,
	// key arriving from the level below, moving up
	input  bhpq_pkg::tok_t                          up_in,
	input  logic [bhpq_pkg::ofs_w(CAPACITY)-1:0]    up_in_ofs,
	// key handed on
	output bhpq_pkg::tok_t                          dn_out,
	output logic [bhpq_pkg::ofs_w(CAPACITY)-1:0]    dn_out_ofs,
	output bhpq_pkg::tok_t                          up_out,
	output logic [bhpq_pkg::ofs_w(CAPACITY)-1:0]    up_out_ofs,
	// read requests into this level from its neighbors
	input  logic                                    crd_in_valid,
	input  logic [bhpq_pkg::ofs_w(CAPACITY)-1:0]    crd_in_ofs,
	input  logic                                    prd_in_valid,
	input  logic [bhpq_pkg::ofs_w(CAPACITY)-1:0]    prd_in_ofs,
	input  logic [bhpq_pkg::ofs_w(CAPACITY)-1:0]    fetch_ofs,
	// read requests out to the neighbors
	output logic                                    crd_out_valid,
	output logic [bhpq_pkg::ofs_w(CAPACITY)-1:0]    crd_out_ofs,
	output logic                                    prd_out_valid,
	output logic [bhpq_pkg::ofs_w(CAPACITY)-1:0]    prd_out_ofs,
	// bank read data: own, from below and from above
	output bhpq_pkg::key_t                          rd_even,
	output bhpq_pkg::key_t                          rd_odd,
	input  bhpq_pkg::key_t                          below_even,
	input  bhpq_pkg::key_t                          below_odd,
	input  bhpq_pkg::key_t                          above_even,
	input  bhpq_pkg::key_t                          above_odd,
	output bhpq_pkg::cell_stat_t                    stat
);

	import bhpq_pkg::*;

	localparam int CW         = cnt_w(CAPACITY);
	localparam int OW         = ofs_w(CAPACITY);
	localparam int RW         = row_w(CAPACITY);
	localparam int EW         = CW + 2;
	localparam int LVL_BASE   = 2**LEVEL - 1;
	localparam int LVL_N      = (CAPACITY - LVL_BASE < 2**LEVEL) ?
	                            CAPACITY - LVL_BASE : 2**LEVEL;
	localparam int EVEN_D     = (LVL_N + 1) / 2;
	localparam int ODD_D      = (LVL_N / 2 > 1) ? LVL_N / 2 : 1;
	localparam int EVEN_AW    = addr_w(EVEN_D);
	localparam int ODD_AW     = addr_w(ODD_D);
	localparam int CHILD_BASE = 2**(LEVEL + 1) - 1;

	cell_phase_t      phase_q, phase_d;
	key_t             val_q;
	logic [OW-1:0]    ofs_q;
	logic             cap_dn, cap_up;

	logic [RW-1:0]    rd_row;
	logic             we;
	logic [OW-1:0]    wr_ofs;
	key_t             wr_val;
	logic             done;

	logic [EW-1:0]    l_slot;
	logic             l_ok, r_ok;
	logic             take_l, take_r;
	key_t             best_child;
	logic             move_dn;
	logic [OW-1:0]    p_ofs;
	key_t             p_val;

	// pick the better child against the held key
	always_comb begin
		l_slot     = EW'(CHILD_BASE) + (EW'(ofs_q) << 1);
		l_ok       = l_slot < EW'(count);
		r_ok       = (l_slot + EW'(1)) < EW'(count);
		take_l     = l_ok && ranks_above(below_even, val_q, largest);
		best_child = take_l ? below_even : val_q;
		take_r     = r_ok && ranks_above(below_odd, best_child, largest);
		if (take_r) begin
			best_child = below_odd;
		end
		move_dn    = take_l || take_r;
	end

	// select the parent out of the level above
	assign p_ofs = ofs_q >> 1;
	assign p_val = p_ofs[0] ? above_odd : above_even;

	// advance the level phase and drive moves and writes
	always_comb begin
		phase_d       = phase_q;
		cap_dn        = 1'b0;
		cap_up        = 1'b0;
		dn_out        = '{valid: 1'b0, value: val_q};
		dn_out_ofs    = OW'({ofs_q, take_r});
		up_out        = '{valid: 1'b0, value: val_q};
		up_out_ofs    = p_ofs;
		crd_out_valid = 1'b0;
		crd_out_ofs   = dn_in_ofs;
		prd_out_valid = 1'b0;
		prd_out_ofs   = up_in_ofs >> 1;
		we            = 1'b0;
		wr_ofs        = ofs_q;
		wr_val        = val_q;
		done          = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (dn_in.valid) begin
					cap_dn        = 1'b1;
					crd_out_valid = 1'b1;
					phase_d       = PH_DN;
				end else if (up_in.valid) begin
					if (LEVEL == 0) begin
						we     = 1'b1;
						wr_ofs = up_in_ofs;
						wr_val = up_in.value;
						done   = 1'b1;
					end else begin
						cap_up        = 1'b1;
						prd_out_valid = 1'b1;
						phase_d       = PH_UP;
					end
				end
			end
			PH_DN: begin
				we      = 1'b1;
				phase_d = PH_IDLE;
				if (move_dn) begin
					wr_val       = best_child;
					dn_out.valid = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
			PH_UP: begin
				we      = 1'b1;
				phase_d = PH_IDLE;
				if (ranks_above(val_q, p_val, largest)) begin
					wr_val       = p_val;
					up_out.valid = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// hold the level phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// hold the key being moved and its slot offset
	always_ff @(posedge clk) begin
		if (cap_dn) begin
			val_q <= dn_in.value;
			ofs_q <= dn_in_ofs;
		end else if (cap_up) begin
			val_q <= up_in.value;
			ofs_q <= up_in_ofs;
		end
	end

	// serve child reads first, then parent reads, else the fetch row
	always_comb begin
		if (crd_in_valid) begin
			rd_row = RW'(crd_in_ofs);
		end else if (prd_in_valid) begin
			rd_row = RW'(prd_in_ofs >> 1);
		end else begin
			rd_row = RW'(fetch_ofs >> 1);
		end
	end

	bhpq_ram #(
		.WIDTH (KEY_W),
		.DEPTH (EVEN_D)
	) u_even (
		.clk   (clk),
		.we    (we && !wr_ofs[0]),
		.waddr (EVEN_AW'(wr_ofs >> 1)),
		.wdata (wr_val),
		.raddr (EVEN_AW'(rd_row)),
		.rdata (rd_even)
	);

	bhpq_ram #(
		.WIDTH (KEY_W),
		.DEPTH (ODD_D)
	) u_odd (
		.clk   (clk),
		.we    (we && wr_ofs[0]),
		.waddr (ODD_AW'(wr_ofs >> 1)),
		.wdata (wr_val),
		.raddr (ODD_AW'(rd_row)),
		.rdata (rd_odd)
	);

	assign stat = '{done: done, wr: we, wr_value: wr_val};

endmodule

>>> hw/rtl/binary_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue: heap of signed keys, one cell per heap level
// A push enters its key at the first free slot and lets it climb; a pop moves
// the last entry to the root and lets it sink. A refused push, an empty pop and
// a last-entry pop skip the sift and go straight to the result.
// One word is in flight at a time: the next word is taken the cycle after the
// result is loaded.
// Reset clears the count and order bit; the key store is not cleared.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
	parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bhpq_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bhpq_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);

	import bhpq_pkg::*;

	localparam int LEVELS = $clog2(CAPACITY + 1);
	localparam int CW     = cnt_w(CAPACITY);
	localparam int OW     = ofs_w(CAPACITY);
	localparam int LVW    = lvl_w(CAPACITY);

	hpq_state_t      state_q, state_d;
	logic [CW-1:0]   cnt_q;
	logic            largest_q;
	logic            out_valid_q;
	out_word_t       out_q;
	key_t            root_q, popped_q, key_q;
	logic [1:0]      status_q;
	logic [LVW-1:0]  op_lvl_q, calc_lvl;
	logic [OW-1:0]   op_ofs_q, calc_ofs;
	logic [CW-1:0]   calc_slot;

	logic            accept, is_full, is_empty, out_free, load_out;
	logic            inj_dn, inj_up, done_any;
	key_t            fetched;

	tok_t            dn_tok [LEVELS];
	logic [OW-1:0]   dn_ofs [LEVELS];
	tok_t            up_tok [LEVELS];
	logic [OW-1:0]   up_ofs [LEVELS];
	tok_t            dn_out [LEVELS];
	logic [OW-1:0]   dn_out_ofs [LEVELS];
	tok_t            up_out [LEVELS];
	logic [OW-1:0]   up_out_ofs [LEVELS];
	tok_t            up_nb [LEVELS];
	logic [OW-1:0]   up_nb_ofs [LEVELS];
	logic [LEVELS-1:0] crd_in_v, crd_out_v, prd_in_v, prd_out_v, cell_done;
	logic [OW-1:0]   crd_in_ofs [LEVELS];
	logic [OW-1:0]   crd_out_ofs [LEVELS];
	logic [OW-1:0]   prd_in_ofs [LEVELS];
	logic [OW-1:0]   prd_out_ofs [LEVELS];
	key_t            rd_even [LEVELS];
	key_t            rd_odd [LEVELS];
	key_t            below_e [LEVELS];
	key_t            below_o [LEVELS];
	key_t            above_e [LEVELS];
	key_t            above_o [LEVELS];
	cell_stat_t      stat [LEVELS];

	assign accept   = in_valid && !in_stall;
	assign is_full  = cnt_q == CW'(CAPACITY);
	assign is_empty = cnt_q == '0;
	assign out_free = !out_valid_q || !out_stall;
	assign done_any = |cell_done;
	assign fetched  = op_ofs_q[0] ? rd_odd[op_lvl_q] : rd_even[op_lvl_q];

	// locate the slot one past the target: push uses count+1, pop uses count
	always_comb begin
		calc_slot = (in_data.cmd == CMD_PUSH) ? cnt_q + CW'(1) : cnt_q;
		calc_lvl  = '0;
		for (int i = 0; i < CW; i++) begin
			if (calc_slot[i]) begin
				calc_lvl = LVW'(i);
			end
		end
		calc_ofs = OW'(calc_slot & ~(CW'(1) << calc_lvl));
	end

	// sequence one word: start the sift, wait for it, then deliver
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		inj_dn   = 1'b0;
		inj_up   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (accept) begin
					if (in_data.cmd == CMD_PUSH) begin
						state_d = is_full ? ST_DONE : ST_PUSH;
					end else if (is_empty || cnt_q == CW'(1)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_PUSH: begin
				inj_up  = 1'b1;
				state_d = done_any ? ST_DONE : ST_RUN;
			end
			ST_FETCH: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				inj_dn  = 1'b1;
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (done_any) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold control state, count, order bit and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			largest_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				largest_q <= cfg_wdata;
			end
			if (accept) begin
				if (in_data.cmd == CMD_PUSH && !is_full) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (in_data.cmd == CMD_POP && !is_empty) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture operation fields, root mirror and the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= in_data.key;
			op_lvl_q <= calc_lvl;
			op_ofs_q <= calc_ofs;
			popped_q <= (in_data.cmd == CMD_POP && !is_empty) ? root_q : '0;
			if (in_data.cmd == CMD_PUSH) begin
				status_q <= is_full ? STAT_FULL : STAT_OK;
			end else begin
				status_q <= is_empty ? STAT_EMPTY : STAT_OK;
			end
		end
		if (stat[0].wr) begin
			root_q <= stat[0].wr_value;
		end
		if (load_out) begin
			out_q.popped_key   <= popped_q;
			out_q.status       <= status_q;
			out_q.stored_count <= COUNT_FIELD_W'(cnt_q);
			out_q.top_key      <= is_empty ? '0 : root_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// chain the level cells
	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		logic inj_hit;

		if (l == 0) begin : g_head
			assign dn_tok[l]     = '{valid: inj_dn, value: fetched};
			assign dn_ofs[l]     = '0;
			assign crd_in_v[l]   = 1'b0;
			assign crd_in_ofs[l] = '0;
			assign above_e[l]    = '0;
			assign above_o[l]    = '0;
		end else begin : g_link_up
			assign dn_tok[l]     = dn_out[l-1];
			assign dn_ofs[l]     = dn_out_ofs[l-1];
			assign crd_in_v[l]   = crd_out_v[l-1];
			assign crd_in_ofs[l] = crd_out_ofs[l-1];
			assign above_e[l]    = rd_even[l-1];
			assign above_o[l]    = rd_odd[l-1];
		end

		if (l == LEVELS - 1) begin : g_tail
			assign up_nb[l]      = '{valid: 1'b0, value: key_q};
			assign up_nb_ofs[l]  = '0;
			assign prd_in_v[l]   = 1'b0;
			assign prd_in_ofs[l] = '0;
			assign below_e[l]    = '0;
			assign below_o[l]    = '0;
		end else begin : g_link_dn
			assign up_nb[l]      = up_out[l+1];
			assign up_nb_ofs[l]  = up_out_ofs[l+1];
			assign prd_in_v[l]   = prd_out_v[l+1];
			assign prd_in_ofs[l] = prd_out_ofs[l+1];
			assign below_e[l]    = rd_even[l+1];
			assign below_o[l]    = rd_odd[l+1];
		end

		// enter a pushed key at the level of its first free slot
		assign inj_hit      = inj_up && (op_lvl_q == LVW'(l));
		assign up_tok[l]    = inj_hit ? '{valid: 1'b1, value: key_q} : up_nb[l];
		assign up_ofs[l]    = inj_hit ? op_ofs_q : up_nb_ofs[l];
		assign cell_done[l] = stat[l].done;

		bhpq_cell #(
			.CAPACITY (CAPACITY),
			.LEVEL    (l)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.largest       (largest_q),
			.count         (cnt_q),
			.dn_in         (dn_tok[l]),
			.dn_in_ofs     (dn_ofs[l]),
			.up_in         (up_tok[l]),
			.up_in_ofs     (up_ofs[l]),
			.dn_out        (dn_out[l]),
			.dn_out_ofs    (dn_out_ofs[l]),
			.up_out        (up_out[l]),
			.up_out_ofs    (up_out_ofs[l]),
			.crd_in_valid  (crd_in_v[l]),
			.crd_in_ofs    (crd_in_ofs[l]),
			.prd_in_valid  (prd_in_v[l]),
			.prd_in_ofs    (prd_in_ofs[l]),
			.fetch_ofs     (op_ofs_q),
			.crd_out_valid (crd_out_v[l]),
			.crd_out_ofs   (crd_out_ofs[l]),
			.prd_out_valid (prd_out_v[l]),
			.prd_out_ofs   (prd_out_ofs[l]),
			.rd_even       (rd_even[l]),
			.rd_odd        (rd_odd[l]),
			.below_even    (below_e[l]),
			.below_odd     (below_o[l]),
			.above_even    (above_e[l]),
			.above_odd     (above_o[l]),
			.stat          (stat[l])
		);
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_done_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done_any |-> (state_q == ST_RUN || state_q == ST_PUSH))
		else $error("sift finished outside a walk");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && status_q == STAT_FULL
		|=> out_data.stored_count == COUNT_FIELD_W'(CAPACITY))
		else $error("refused push reports a count other than capacity");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && status_q == STAT_EMPTY
		|=> out_data.stored_count == '0 && out_data.top_key == '0 && out_data.popped_key == '0)
		else $error("empty pop reports held data");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted word did not start the sequencer");
`endif

endmodule
